// ===== rtl/segregated_free_list_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the allocator RTL
// ---------------------------------------------------------------------------
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_MACROS_SVH

// Check an implication on every rising clock edge once reset is released.
`define SFLA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle.
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfla_pkg.sv =====
// ---------------------------------------------------------------------------
// sfla_pkg
// Types and constants of the segregated free-list allocator.
// ---------------------------------------------------------------------------
package sfla_pkg;

    localparam logic       ACT_ALLOC = 1'b0;
    localparam logic       ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_OOM      = 2'd2;

    localparam logic       CFG_POOL_LIMIT   = 1'b0;
    localparam logic       CFG_REFILL_COUNT = 1'b1;

    localparam int REFILL_MAX = 64;

    typedef struct packed {
        logic        action;
        logic [15:0] req_size;
        logic [15:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [15:0] grant_addr;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_POP,
        S_CARVE,
        S_LEFT,
        S_SCAN,
        S_SPOP,
        S_LINK,
        S_CLEAR,
        S_DONE
    } state_t;

endpackage

// ===== rtl/segregated_free_list_allocator.sv =====
// ---------------------------------------------------------------------------
// segregated_free_list_allocator
// Small-block pool allocator with one LIFO free list per size class.
// ---------------------------------------------------------------------------
// Sequence from the accepting edge to done: too_large goes straight to DONE; free passes HEAD;
// a class hit passes HEAD and POP; a refill from the pool passes HEAD, CARVE, then LINK for the
// blocks carved (up to refill_count); a scavenge adds LEFT, SCAN per size tried and SPOP.
// Throughput: one request at a time, the next start is taken in the cycle after done.
// Reset: classes empty, pool [0, pool_limit); no clearing pass. done pulses once per request.
`include "segregated_free_list_allocator_macros.svh"

module segregated_free_list_allocator #(
    parameter int POOL_BYTES  = 65536,
    parameter int ALIGN_BYTES = 8,
    parameter int MAX_SMALL   = 128,
    parameter int NUM_CLASSES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sfla_pkg::req_t    req,
    output logic              done,
    output sfla_pkg::rsp_t    rsp,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [16:0]       cfg_wdata
);

    localparam int LINK_DEPTH = POOL_BYTES / ALIGN_BYTES;
    localparam int AW  = $clog2(POOL_BYTES) + 1;   // address incl. end value
    localparam int SW  = $clog2(LINK_DEPTH);
    localparam int CW  = $clog2(NUM_CLASSES);
    localparam int AB  = $clog2(ALIGN_BYTES);

    // ---- Registers ---------------------------------------------------------
    sfla_pkg::state_t state_reg, state_next;
    logic [AW-1:0] pool_cursor_reg, pool_cursor_next;
    logic [AW-1:0] pool_end_reg, pool_end_next;
    logic [16:0]   pool_limit_reg;
    logic [6:0]    refill_reg;
    logic [AW-1:0] head_reg [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] hvalid_reg;

    logic          act_reg;
    logic [AW-1:0] rs_reg, rs_next;        // rounded size
    logic [CW-1:0] cls_reg, cls_next;
    logic [AW-1:0] addr_reg;
    logic [6:0]    n_reg, n_next;           // blocks to carve at most
    logic [6:0]    k_reg, k_next;           // link walk index
    logic [AW-1:0] chunk_reg, chunk_next;
    logic [AW-1:0] scan_reg, scan_next;     // scavenged size
    logic          pass_reg, pass_next;
    logic [15:0]   grant_reg, grant_next;
    logic [1:0]    status_reg, status_next;
    logic [CW-1:0] scls_reg, scls_next;     // scavenge class

    // ---- Link memory: next pointer and valid in one word -------------------
    logic [AW:0]   link_mem [LINK_DEPTH];
    logic [AW:0]   link_rdata;
    logic          link_we;
    logic [SW-1:0] link_waddr, link_raddr;
    logic [AW:0]   link_wdata;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata <= link_mem[link_raddr];
    end

    function automatic logic [CW-1:0] class_of(input logic [AW-1:0] bytes);
        logic [AW-1:0] k;
        begin
            k = AW'((bytes + AW'(ALIGN_BYTES - 1)) >> AB);
            if (k == '0)
            begin
                k = AW'(1);
            end
            k = k - AW'(1);
            if (k >= AW'(NUM_CLASSES))
            begin
                k = AW'(NUM_CLASSES - 1);
            end
            class_of = CW'(k);
        end
    endfunction

    function automatic logic [SW-1:0] slot_of(input logic [AW-1:0] a);
        slot_of = SW'(a >> AB);
    endfunction

    function automatic logic [AW-1:0] eff_limit(input logic [16:0] v);
        logic [AW:0] c;
        begin
            c = ({1'b0, AW'(v)} > (AW+1)'(POOL_BYTES)) ? (AW+1)'(POOL_BYTES)
                                                       : (AW+1)'(v);
            eff_limit = AW'((c >> AB) << AB);
        end
    endfunction

    // ---- Request decode ----------------------------------------------------
    logic [AW-1:0] size_in, rs_in;
    logic          too_large;
    always_comb
    begin
        size_in = (req.req_size == '0) ? AW'(ALIGN_BYTES) : AW'(req.req_size);
        rs_in   = AW'(((size_in + AW'(ALIGN_BYTES - 1)) >> AB) << AB);
        too_large = (size_in > AW'(MAX_SMALL));
    end

    // Pool state for carving: the block at the cursor and the one after it
    logic [AW-1:0] left;
    logic [AW-1:0] blk_end, blk2_end;
    logic          blk_fits, next_fits;
    always_comb
    begin
        left      = (pool_end_reg > pool_cursor_reg) ? pool_end_reg - pool_cursor_reg : '0;
        blk_end   = pool_cursor_reg + rs_reg;
        blk2_end  = blk_end + rs_reg;
        blk_fits  = (k_reg < n_reg) && (blk_end <= pool_end_reg);
        next_fits = ((k_reg + 7'd1) < n_reg) && (blk2_end <= pool_end_reg);
    end

    logic accept;
    assign accept = start && !busy;

    // ---- Next-state and datapath ------------------------------------------
    logic [AW-1:0]          head_wval;
    logic [CW-1:0]          head_widx;
    logic                   head_we, head_wvalid;
    logic                   clear_all;

    always_comb
    begin
        state_next = state_reg;
        pool_cursor_next = pool_cursor_reg;
        pool_end_next = pool_end_reg;
        rs_next = rs_reg;
        cls_next = cls_reg;
        n_next = n_reg;
        k_next = k_reg;
        chunk_next = chunk_reg;
        scan_next = scan_reg;
        pass_next = pass_reg;
        grant_next = grant_reg;
        status_next = status_reg;
        scls_next = scls_reg;
        link_we = 1'b0;
        link_waddr = slot_of(addr_reg);
        link_wdata = {hvalid_reg[cls_reg], head_reg[cls_reg]};
        link_raddr = slot_of(head_reg[cls_reg]);
        head_we = 1'b0;
        head_widx = cls_reg;
        head_wval = addr_reg;
        head_wvalid = 1'b1;
        clear_all = 1'b0;
        case (state_reg)
            sfla_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rs_next = rs_in;
                    cls_next = class_of(size_in);
                    grant_next = '0;
                    status_next = sfla_pkg::ST_OK;
                    pass_next = 1'b0;
                    n_next = (refill_reg == '0) ? 7'd1 :
                             (refill_reg > 7'(sfla_pkg::REFILL_MAX)) ?
                             7'(sfla_pkg::REFILL_MAX) : refill_reg;
                    state_next = too_large ? sfla_pkg::S_DONE : sfla_pkg::S_HEAD;
                    if (too_large)
                    begin
                        status_next = sfla_pkg::ST_TOO_LARGE;
                    end
                end
            end
            sfla_pkg::S_HEAD:
            begin
                if (act_reg == sfla_pkg::ACT_FREE)
                begin
                    link_we = 1'b1;
                    head_we = 1'b1;
                    state_next = sfla_pkg::S_DONE;
                end
                else if (hvalid_reg[cls_reg])
                begin
                    // link read issued this cycle
                    grant_next = 16'(head_reg[cls_reg]);
                    state_next = sfla_pkg::S_POP;
                end
                else
                begin
                    state_next = sfla_pkg::S_CARVE;
                end
            end
            sfla_pkg::S_POP:
            begin
                head_we = 1'b1;
                head_wval = link_rdata[AW-1:0];
                head_wvalid = link_rdata[AW];
                state_next = sfla_pkg::S_DONE;
            end
            sfla_pkg::S_CARVE:
            begin
                if (left >= rs_reg)
                begin
                    // grant the first block, link the rest one per cycle
                    chunk_next = pool_cursor_reg;
                    grant_next = 16'(pool_cursor_reg);
                    pool_cursor_next = blk_end;
                    k_next = 7'd1;
                    state_next = sfla_pkg::S_LINK;
                end
                else if (pass_reg)
                begin
                    pool_cursor_next = pool_end_reg;
                    status_next = sfla_pkg::ST_OOM;
                    state_next = sfla_pkg::S_DONE;
                end
                else
                begin
                    state_next = sfla_pkg::S_LEFT;
                end
            end
            sfla_pkg::S_LEFT:
            begin
                // push the remainder onto its own class
                if (left != '0)
                begin
                    head_widx = class_of(left);
                    head_wval = pool_cursor_reg;
                    head_we = 1'b1;
                    link_we = 1'b1;
                    link_waddr = slot_of(pool_cursor_reg);
                    link_wdata = {hvalid_reg[class_of(left)], head_reg[class_of(left)]};
                end
                pool_cursor_next = pool_end_reg;
                scan_next = rs_reg;
                scls_next = class_of(rs_reg);
                state_next = sfla_pkg::S_SCAN;
            end
            sfla_pkg::S_SCAN:
            begin
                link_raddr = slot_of(head_reg[scls_reg]);
                if (scan_reg > AW'(MAX_SMALL))
                begin
                    status_next = sfla_pkg::ST_OOM;
                    state_next = sfla_pkg::S_DONE;
                end
                else if (hvalid_reg[scls_reg])
                begin
                    pool_cursor_next = head_reg[scls_reg];
                    pool_end_next = head_reg[scls_reg] + scan_reg;
                    state_next = sfla_pkg::S_SPOP;
                end
                else
                begin
                    scan_next = scan_reg + AW'(ALIGN_BYTES);
                    scls_next = class_of(scan_reg + AW'(ALIGN_BYTES));
                end
            end
            sfla_pkg::S_SPOP:
            begin
                head_widx = scls_reg;
                head_we = 1'b1;
                head_wval = link_rdata[AW-1:0];
                head_wvalid = link_rdata[AW];
                pass_next = 1'b1;
                state_next = sfla_pkg::S_CARVE;
            end
            sfla_pkg::S_LINK:
            begin
                if (blk_fits)
                begin
                    // block k sits at the cursor; point it at block k+1 if that fits
                    link_we = 1'b1;
                    link_waddr = slot_of(pool_cursor_reg);
                    link_wdata = next_fits ? {1'b1, blk_end} : '0;
                    pool_cursor_next = blk_end;
                    k_next = k_reg + 7'd1;
                end
                else
                begin
                    if (k_reg > 7'd1)
                    begin
                        head_we = 1'b1;
                        head_wval = chunk_reg + rs_reg;
                    end
                    state_next = sfla_pkg::S_DONE;
                end
            end
            sfla_pkg::S_DONE:
            begin
                state_next = sfla_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sfla_pkg::S_IDLE;
            end
        endcase
        // A pool_limit write empties all classes and resets the pool to [0, new limit).
        if (cfg_we && cfg_index == sfla_pkg::CFG_POOL_LIMIT)
        begin
            clear_all = 1'b1;
            pool_cursor_next = '0;
            pool_end_next = eff_limit(cfg_wdata);
        end
    end

    // ---- Register update ---------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sfla_pkg::S_IDLE;
            pool_limit_reg  <= 17'd65536;
            refill_reg      <= 7'd20;
            pool_cursor_reg <= '0;
            pool_end_reg    <= eff_limit(17'd65536);
            hvalid_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            pool_cursor_reg <= pool_cursor_next;
            pool_end_reg    <= pool_end_next;
            if (clear_all)
            begin
                hvalid_reg <= '0;
            end
            else if (head_we)
            begin
                hvalid_reg[head_widx] <= head_wvalid;
            end
            if (cfg_we)
            begin
                if (cfg_index == sfla_pkg::CFG_POOL_LIMIT)
                begin
                    pool_limit_reg <= cfg_wdata;
                end
                else
                begin
                    refill_reg <= cfg_wdata[6:0];
                end
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        rs_reg     <= rs_next;
        cls_reg    <= cls_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        chunk_reg  <= chunk_next;
        scan_reg   <= scan_next;
        pass_reg   <= pass_next;
        grant_reg  <= grant_next;
        status_reg <= status_next;
        scls_reg   <= scls_next;
        if (accept)
        begin
            act_reg  <= req.action;
            addr_reg <= AW'(req.block_addr);
        end
        if (head_we)
        begin
            head_reg[head_widx] <= head_wval;
        end
    end

    // ---- Outputs -----------------------------------------------------------
    always_comb
    begin
        busy = (state_reg != sfla_pkg::S_IDLE);
        done = (state_reg == sfla_pkg::S_DONE);
        rsp.status = status_reg;
        rsp.grant_addr = (status_reg == sfla_pkg::ST_OK &&
                          act_reg == sfla_pkg::ACT_ALLOC) ? grant_reg : '0;
    end

    logic unused_ok;
    assign unused_ok = ^pool_limit_reg;

    // ---- Assertions --------------------------------------------------------
    `SFLA_ASSERT_NEXT(a_done_one_cycle, clk, rst_n, done, !done,
        "done held over two cycles")
    `SFLA_ASSERT_IMPL(a_err_no_grant, clk, rst_n,
        done && rsp.status != sfla_pkg::ST_OK, rsp.grant_addr == '0, "grant on error")
    `SFLA_ASSERT_IMPL(a_cursor_bound, clk, rst_n,
        state_reg == sfla_pkg::S_DONE && rsp.status == sfla_pkg::ST_OK,
        pool_cursor_reg <= pool_end_reg, "cursor past pool end")

endmodule
